[hdl/xoroshiro128plus_random_source_top_assert.svh]
// Assertion macros shared by the random source RTL.
// Needs only a clock and an active-low reset in scope at the point of use.
`ifndef XOROSHIRO128PLUS_RANDOM_SOURCE_TOP_ASSERT_SVH
`define XOROSHIRO128PLUS_RANDOM_SOURCE_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset
`define XRS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset
`define XRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/xrs_pkg.sv]
// Package for the xoroshiro128+ random source: constants, sequencer states
// and multiplier request/response types. No dependencies.
`timescale 1ns / 1ps

package xrs_pkg;

  localparam int unsigned LaneW  = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned EarlyN = 3;

  localparam logic [LaneW-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [LaneW-1:0] MIX_MUL_ONE  = 64'hBF58476D1CE4E5B9;
  localparam logic [LaneW-1:0] MIX_MUL_TWO  = 64'h94D049BB133111EB;

  // key word count saturates here
  localparam logic [2:0] KEY_SAT = 3'd4;

  // item codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  // splitmix seeding sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_MUL1,
    ST_MID,
    ST_MUL2,
    ST_POST
  } xrs_state_t;

  typedef struct packed {
    logic             start;
    logic [LaneW-1:0] a;
    logic [LaneW-1:0] b;
  } xrs_mul_req_t;

  typedef struct packed {
    logic             done;
    logic [LaneW-1:0] product;
  } xrs_mul_rsp_t;

endpackage

[hdl/xrs_channels_if.sv]
// Valid/ready channel interfaces for the random source: input items and results.
// Depends on nothing.
`timescale 1ns / 1ps

interface xrs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] key_word;
  logic        key_last;

  modport source (output valid, output op, output key_word, output key_last, input ready);
  modport sink   (input valid, input op, input key_word, input key_last, output ready);
endinterface

interface xrs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

[hdl/xrs_mul64.sv]
// Iterative 64x64 multiplier keeping the low 64 bits, one 32x32 product per cycle.
// Depends on xrs_pkg.
`timescale 1ns / 1ps

module xrs_mul64
  import xrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  xrs_mul_req_t req,
  output xrs_mul_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             done_r, done_nxt;
  logic [LaneW-1:0] a_r, a_nxt;
  logic [LaneW-1:0] b_r, b_nxt;
  logic [LaneW-1:0] prod_r, prod_nxt;
  logic [LaneW-1:0] acc_r, acc_nxt;
  logic [WordW-1:0] mul_x, mul_y;

  // operand select: low*low, low*high, high*low
  always_comb begin
    mul_x = (phase_r == 2'd2) ? a_r[LaneW-1:WordW] : a_r[WordW-1:0];
    mul_y = (phase_r == 2'd1) ? b_r[LaneW-1:WordW] : b_r[WordW-1:0];
  end

  // step control, the low*low product and accumulation of the cross terms into the upper half
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 2'd0;
      a_nxt     = req.a;
      b_nxt     = req.b;
    end else if (busy_r) begin
      prod_nxt  = {{WordW{1'b0}}, mul_x} * {{WordW{1'b0}}, mul_y};
      phase_nxt = phase_r + 2'd1;
      case (phase_r)
        2'd0: acc_nxt = acc_r;
        2'd1: acc_nxt = prod_r;
        2'd2, 2'd3: acc_nxt = acc_r + {prod_r[WordW-1:0], {WordW{1'b0}}};
        default: acc_nxt = acc_r;
      endcase
      if (phase_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

[hdl/xoroshiro128plus_random_source_top.sv]
// Top level of the xoroshiro128+ random source with word-serial seeding.
// Depends on xrs_pkg, xrs_channels_if, xrs_mul64 and the assertion macro header.
//
//   channel | dir | payload                     | per word
//   in_if   | in  | op, key_word[31:0], key_last| draw or one seed key word
//   out_if  | out | random_value[31:0]          | one per draw, none per key word
//
// A draw or a seed key word is taken only while the sequencer is idle and the
// output register is empty or being read; a draw's result sits in that register.
// The final word of a one-to-three word key sequence starts splitmix seeding:
// two mix steps, each with two passes through the shared 64x64 multiplier
// (four 32x32 products per pass), and no new item is taken until it is done.
// Reset (synchronous, active low) clears the lanes, half flag and seed state.
`timescale 1ns / 1ps

`include "xoroshiro128plus_random_source_top_assert.svh"

module xoroshiro128plus_random_source_top
  import xrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  xrs_in_if.sink    in_if,
  xrs_out_if.source out_if
);

  xrs_state_t       state_r, state_nxt;
  logic [LaneW-1:0] lane0_r, lane0_nxt;
  logic [LaneW-1:0] lane1_r, lane1_nxt;
  logic [WordW-1:0] saved_r, saved_nxt;
  logic             pending_r, pending_nxt;
  logic             seeding_r, seeding_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             parity_r, parity_nxt;
  logic [WordW-1:0] early_r [EarlyN];
  logic [WordW-1:0] early_nxt [EarlyN];
  logic [LaneW-1:0] t_r, t_nxt;
  logic [LaneW-1:0] z_r, z_nxt;
  logic             which_r, which_nxt;
  logic [2:0]       words_r, words_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_value_r, out_value_nxt;

  logic             in_ready;
  logic             in_acc;
  xrs_mul_req_t     mul_req;
  xrs_mul_rsp_t     mul_rsp;

  logic [LaneW-1:0] sum, x_lane, step0, step1;
  logic [LaneW-1:0] base0, base1;
  logic [2:0]       cnt_base, cnt_inc;
  logic             par_base;
  logic [LaneW-1:0] key64, t_first;
  logic [LaneW-1:0] pre_acc, pre_mix, mid_mix, fin_mix;

  assign in_acc = in_if.valid && in_ready;

  // xoroshiro128+ step
  always_comb begin
    sum    = lane0_r + lane1_r;
    x_lane = lane1_r ^ lane0_r;
    step0  = {lane0_r[8:0], lane0_r[63:9]} ^ x_lane ^ (x_lane << 14);
    step1  = {x_lane[27:0], x_lane[63:28]};
  end

  // seed word view: a new sequence starts from cleared lanes and count
  always_comb begin
    base0    = seeding_r ? lane0_r : '0;
    base1    = seeding_r ? lane1_r : '0;
    cnt_base = seeding_r ? cnt_r : 3'd0;
    par_base = seeding_r ? parity_r : 1'b0;
    cnt_inc  = (cnt_base < KEY_SAT) ? cnt_base + 3'd1 : cnt_base;
    key64    = {{(LaneW-WordW){1'b0}}, in_if.key_word};
    for (int i = 0; i < EarlyN; i++) early_nxt[i] = early_r[i];
    if (in_acc && in_if.op == OP_SEED && cnt_base < 3'(EarlyN))
      early_nxt[cnt_base[1:0]] = in_if.key_word;
    t_first = {{(LaneW-WordW){1'b0}},
               early_nxt[0] | ((cnt_inc > 3'd1) ? early_nxt[1] : '0)};
  end

  // splitmix stages around the multiplier
  always_comb begin
    pre_acc = t_r + GOLDEN_GAMMA;
    pre_mix = pre_acc ^ (pre_acc >> 30);
    mid_mix = z_r ^ (z_r >> 27);
    fin_mix = z_r ^ (z_r >> 31);
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_if.op == OP_SEED && in_if.key_last && cnt_inc < KEY_SAT)
          state_nxt = ST_PRE;
      end
      ST_PRE:  state_nxt = ST_MUL1;
      ST_MUL1: if (mul_rsp.done) state_nxt = ST_MID;
      ST_MID:  state_nxt = ST_MUL2;
      ST_MUL2: if (mul_rsp.done) state_nxt = ST_POST;
      ST_POST: state_nxt = which_r ? ST_IDLE : ST_PRE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready      = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
    mul_req.start = (state_r == ST_PRE) || (state_r == ST_MID);
    mul_req.a     = (state_r == ST_PRE) ? pre_mix : mid_mix;
    mul_req.b     = (state_r == ST_PRE) ? MIX_MUL_ONE : MIX_MUL_TWO;
  end

  // datapath next values
  always_comb begin
    lane0_nxt     = lane0_r;
    lane1_nxt     = lane1_r;
    saved_nxt     = saved_r;
    pending_nxt   = pending_r;
    seeding_nxt   = seeding_r;
    cnt_nxt       = cnt_r;
    parity_nxt    = parity_r;
    t_nxt         = t_r;
    z_nxt         = z_r;
    which_nxt     = which_r;
    words_nxt     = words_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_value_nxt = out_value_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_if.op == OP_DRAW) begin
          out_valid_nxt = 1'b1;
          if (!pending_r) begin
            lane0_nxt     = step0;
            lane1_nxt     = step1;
            pending_nxt   = 1'b1;
            saved_nxt     = sum[LaneW-1:WordW];
            out_value_nxt = sum[WordW-1:0];
          end else begin
            pending_nxt   = 1'b0;
            out_value_nxt = saved_r;
          end
        end else if (in_acc) begin
          seeding_nxt = !in_if.key_last;
          cnt_nxt     = cnt_inc;
          parity_nxt  = !par_base;
          lane0_nxt   = par_base ? base0 : base0 ^ key64;
          lane1_nxt   = par_base ? base1 ^ key64 : base1;
          if (in_if.key_last && cnt_inc < KEY_SAT) begin
            t_nxt     = t_first;
            words_nxt = cnt_inc;
            which_nxt = 1'b0;
          end
        end
      end
      ST_PRE:  t_nxt = pre_acc;
      ST_MUL1: if (mul_rsp.done) z_nxt = mul_rsp.product;
      ST_MID:  z_nxt = z_r;
      ST_MUL2: if (mul_rsp.done) z_nxt = mul_rsp.product;
      ST_POST: begin
        if (!which_r) begin
          lane0_nxt = fin_mix;
          which_nxt = 1'b1;
          if (words_r > 3'd2) t_nxt = {{(LaneW-WordW){1'b0}}, early_r[2]};
        end else begin
          lane1_nxt = fin_mix;
          if (lane0_r == '0 && fin_mix == '0) lane0_nxt = 64'd1;
        end
      end
      default: lane0_nxt = lane0_r;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lane0_r     <= '0;
      lane1_r     <= '0;
      saved_r     <= '0;
      pending_r   <= 1'b0;
      seeding_r   <= 1'b0;
      cnt_r       <= 3'd0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane0_r     <= lane0_nxt;
      lane1_r     <= lane1_nxt;
      saved_r     <= saved_nxt;
      pending_r   <= pending_nxt;
      seeding_r   <= seeding_nxt;
      cnt_r       <= cnt_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
    end
    for (int i = 0; i < EarlyN; i++) early_r[i] <= early_nxt[i];
    t_r         <= t_nxt;
    z_r         <= z_nxt;
    which_r     <= which_nxt;
    words_r     <= words_nxt;
    out_value_r <= out_value_nxt;
  end

  xrs_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid_r;
  assign out_if.random_value = out_value_r;

  // checks
  `XRS_ASSERT_NOW(a_mul_done_in_wait, clk, rst_n, mul_rsp.done,
    (state_r == ST_MUL1) || (state_r == ST_MUL2), "multiplier done outside a wait state")
  `XRS_ASSERT_NEXT(a_seed_nonzero, clk, rst_n, (state_r == ST_POST) && which_r,
    (lane0_r != '0) || (lane1_r != '0), "splitmix seeding left an all-zero state")
  `XRS_ASSERT_NEXT(a_high_half_out, clk, rst_n,
    in_acc && (in_if.op == OP_DRAW) && pending_r,
    out_valid_r && (out_value_r == $past(saved_r)) && !pending_r,
    "pending high half not returned")

endmodule

[test/xrs_random_value_checker.sv]
// Checker for the xoroshiro128+ random source: watches the item and result channels,
// predicts each random_value and compares it. Depends on xrs_pkg.
`timescale 1ns / 1ps

module xrs_random_value_checker
  import xrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_key_word,
  input  logic        in_key_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_random_value,
  output int          fail_count,
  output int          outstanding
);

  // predicted generator and seeding state
  logic [63:0] lane0;
  logic [63:0] lane1;
  logic [63:0] mix_acc;
  logic [31:0] held_high;
  logic [31:0] first_words [3];
  bit          high_pending;
  bit          seeding;
  bit          odd_word;
  int unsigned word_cnt;
  int          mismatches;

  logic [31:0] expected_values [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    mismatches  = 0;
  end

  // one splitmix64 step on the shared accumulator
  function logic [63:0] splitmix_next();
    logic [63:0] z;
    mix_acc = mix_acc + GOLDEN_GAMMA;
    z = mix_acc;
    z = (z ^ (z >> 30)) * MIX_MUL_ONE;
    z = (z ^ (z >> 27)) * MIX_MUL_TWO;
    return z ^ (z >> 31);
  endfunction

  // xoroshiro128+ step, returns the 64-bit sum output
  function logic [63:0] lanes_advance();
    logic [63:0] sum;
    logic [63:0] s0;
    logic [63:0] s1;
    s0 = lane0;
    s1 = lane1;
    sum = s0 + s1;
    s1 = s1 ^ s0;
    lane0 = ((s0 << 55) | (s0 >> 9)) ^ s1 ^ (s1 << 14);
    lane1 = (s1 << 36) | (s1 >> 28);
    return sum;
  endfunction

  // short key sequence: lanes come from splitmix on the stored words
  function void reseed_from_key_words(int unsigned n);
    mix_acc = {32'd0, first_words[0]};
    if (n > 1) mix_acc = mix_acc | {32'd0, first_words[1]};
    lane0 = splitmix_next();
    if (n > 2) mix_acc = {32'd0, first_words[2]};
    lane1 = splitmix_next();
    if (lane0 == 64'd0 && lane1 == 64'd0) lane0 = 64'd1;
  endfunction

  function void apply_word(logic op, logic [31:0] key, logic last);
    logic [63:0] r;
    if (op == OP_DRAW) begin
      if (!high_pending) begin
        r = lanes_advance();
        high_pending = 1'b1;
        held_high = r[63:32];
        expected_values.push_back(r[31:0]);
      end else begin
        high_pending = 1'b0;
        expected_values.push_back(held_high);
      end
    end else begin
      // first key word of a sequence clears the lanes
      if (!seeding) begin
        seeding  = 1'b1;
        lane0    = 64'd0;
        lane1    = 64'd0;
        word_cnt = 0;
        odd_word = 1'b0;
      end
      if (word_cnt < 3) first_words[word_cnt] = key;
      if (odd_word) lane1 = lane1 ^ {32'd0, key};
      else lane0 = lane0 ^ {32'd0, key};
      odd_word = !odd_word;
      if (word_cnt < 4) word_cnt++;
      if (last) begin
        seeding = 1'b0;
        if (word_cnt < 4) reseed_from_key_words(word_cnt);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lane0        = 64'd0;
      lane1        = 64'd0;
      held_high    = 32'd0;
      high_pending = 1'b0;
      seeding      = 1'b0;
      odd_word     = 1'b0;
      word_cnt     = 0;
      first_words[0] = 32'd0;
      first_words[1] = 32'd0;
      first_words[2] = 32'd0;
      expected_values.delete();
    end else begin
      // result side first: its expectation came from an earlier word
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected random_value %h", $realtime, out_random_value);
        end else if (expected_values[0] !== out_random_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: random_value mismatch: expected %h, got %h",
                     $realtime, expected_values[0], out_random_value);
          void'(expected_values.pop_front());
        end else begin
          void'(expected_values.pop_front());
        end
      end
      if (in_valid && in_ready) apply_word(in_op, in_key_word, in_key_last);
    end
    fail_count  <= mismatches;
    outstanding <= expected_values.size();
  end

endmodule

[test/tb_xoroshiro128plus_random_source_top.sv]
// Testbench top for the xoroshiro128+ random source: drives draws and key sequences
// with random gaps and stalls. Needs xrs_pkg, xrs_channels_if, the top and checker.
`timescale 1ns / 1ps

module tb_xoroshiro128plus_random_source_top;
  import xrs_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int ItemTarget = 1450;

  logic clk;
  logic rst_n;

  xrs_in_if  in_ch ();
  xrs_out_if out_ch ();

  int fail_count;
  int outstanding;
  int idle_cycles;
  int stall_left;
  int items_sent;
  bit in_burst;
  bit out_calm;

  xoroshiro128plus_random_source_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  xrs_random_value_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_op            (in_ch.op),
    .in_key_word      (in_ch.key_word),
    .in_key_last      (in_ch.key_last),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_random_value (out_ch.random_value),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // key words lean toward the extremes and single set bits
  function logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // present one word and hold it until the block takes it
  task automatic push_item(input logic op, input logic [31:0] key, input logic last);
    int gap;
    gap = in_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.key_word <= key;
    in_ch.key_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic push_draw();
    push_item(OP_DRAW, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // result side: random stalls, with calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      out_calm     <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) out_calm <= !out_calm;
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 5) == 0) stall_left <= pick_gap();
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_xoroshiro128plus_random_source_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    int n;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_DRAW;
    in_ch.key_word = 32'd0;
    in_ch.key_last = 1'b0;
    out_ch.ready   = 1'b0;
    items_sent     = 0;
    in_burst       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // all-zero lanes after reset; key fields on a draw are don't-care
    push_item(OP_DRAW, 32'hffff_ffff, 1'b1);
    push_item(OP_DRAW, 32'h0000_0000, 1'b0);
    // one zero word goes through splitmix
    push_item(OP_SEED, 32'h0000_0000, 1'b1);
    // leave the high half pending across a reseed
    push_draw();
    push_item(OP_SEED, 32'hffff_ffff, 1'b0);
    push_item(OP_SEED, 32'h1234_5678, 1'b1);
    push_draw();
    push_draw();
    push_draw();
    // three words, last one taken alone for lane one
    push_item(OP_SEED, 32'h0000_0000, 1'b0);
    push_item(OP_SEED, 32'hffff_ffff, 1'b0);
    push_item(OP_SEED, 32'h0000_0000, 1'b1);
    push_draw();
    push_draw();
    // four zero words leave the lanes all zero
    repeat (3) push_item(OP_SEED, 32'h0000_0000, 1'b0);
    push_item(OP_SEED, 32'h0000_0000, 1'b1);
    push_draw();
    push_draw();
    // long sequence with a draw in the middle
    push_item(OP_SEED, 32'hffff_ffff, 1'b0);
    push_draw();
    push_item(OP_SEED, 32'h0000_0001, 1'b0);
    push_item(OP_SEED, 32'h8000_0000, 1'b0);
    push_item(OP_SEED, 32'hffff_ffff, 1'b0);
    push_item(OP_SEED, 32'h0000_0007, 1'b1);
    push_draw();

    // random part: mostly draws and well-formed key sequences
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_draw();
      end else if (r < 88) begin
        n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) push_draw();
          push_item(OP_SEED, pick_key(), 1'(i == n - 1));
        end
      end else begin
        // stray key word, may leave a sequence open
        push_item(OP_SEED, pick_key(), 1'($urandom_range(0, 1)));
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    // drain, then allow for a seeding pass and a long stall
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_xoroshiro128plus_random_source_top passed");
    end else begin
      $display("tb_xoroshiro128plus_random_source_top failed");
    end
    $finish;
  end

endmodule

[xoroshiro128plus_random_source_top.f]
+incdir+hdl
hdl/xrs_pkg.sv
hdl/xrs_channels_if.sv
hdl/xrs_mul64.sv
hdl/xoroshiro128plus_random_source_top.sv
test/xrs_random_value_checker.sv
test/tb_xoroshiro128plus_random_source_top.sv
